// ===== rtl/bdsv_pkg.sv =====
// shared types and constants for the bond database stream validator
`default_nettype none

package bdsv_pkg;

    // walk phases
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_RECHDR,
        PH_BODY
    } phase_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_ADDR_TYPE_MAX,
        REG_KEY_VALID_MASK,
        REG_LTK_KEY_BIT,
        REG_FLAG_VALID_MASK
    } cfg_reg_t;

    localparam int unsigned MAX_ENTRIES = 16;
    localparam int unsigned ENTRY_CNT_W = $clog2(MAX_ENTRIES + 2);
    localparam int unsigned OUT_CNT_W   = 5;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [4:0]  HDR_LAST    = 5'd19;
    localparam logic [7:0]  HDR_VERSION = 8'd1;
    localparam logic [7:0]  HDR_LEN     = 8'd20;
    localparam logic [15:0] ENTRY_BYTES = 16'd92;
    localparam logic [7:0]  KIND_ENTRY  = 8'd1;
    localparam logic [7:0]  LTK_MIN     = 8'd7;
    localparam logic [7:0]  LTK_MAX     = 8'd16;

    // entry body field offsets
    localparam logic [6:0] OFS_ADAPTER_TYPE = 7'd0;
    localparam logic [6:0] OFS_PEER_TYPE    = 7'd7;
    localparam logic [6:0] OFS_KEYS         = 7'd14;
    localparam logic [6:0] OFS_FLAGS        = 7'd15;
    localparam logic [6:0] OFS_LTK_SIZE     = 7'd59;
    localparam logic [6:0] OFS_SAT          = 7'd127;

    // header magic "BTKD"
    localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h54, 8'h4B, 8'h44};

    // entry count as reported, saturated to the output width
    function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [ENTRY_CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w > 32'((1 << OUT_CNT_W) - 1))
            return '1;
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bdsv_crc8.sv =====
// byte-wide reflected crc-32 update
`default_nettype none

module bdsv_crc8
    import bdsv_pkg::*;
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [31:0] crc_out
);

    // eight bit steps of the reflected polynomial
    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// ===== rtl/bond_database_stream_validator_core.sv =====
// top level: byte stream checker for bond database images
`default_nettype none

// channel   direction  handshake            payload
// in        input      in_valid/in_ready    data_byte, last_byte
// out       output     out_valid/out_ready  accepted, entry_count, payload_crc
// cfg       input      cfg_we               cfg_index, cfg_data
//
// one byte per cycle unless a last byte stalls: input register, combinational checks and crc, result register
// a transfer marked last yields one result, which passes from the input register to the result register
// bytes without last keep flowing while a result waits; a last byte waits for
// the result register to free up
// reset clears the walk state and loads the register defaults

module bond_database_stream_validator_core
    import bdsv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             accepted,
    output logic [4:0]       entry_count,
    output logic [31:0]      payload_crc,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    // configuration registers
    logic [7:0] addr_type_max_reg;
    logic [7:0] key_valid_mask_reg;
    logic [7:0] ltk_key_bit_reg;
    logic [7:0] flag_valid_mask_reg;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // walk state
    phase_t                 phase_reg,        phase_next;
    logic [4:0]             byte_offset_reg,  byte_offset_next;
    logic [15:0]            hdr_count_reg,    hdr_count_next;
    logic [31:0]            decl_len_reg,     decl_len_next;
    logic [31:0]            exp_crc_reg,      exp_crc_next;
    logic [31:0]            crc_reg,          crc_next;
    logic [31:0]            seen_reg,         seen_next;
    logic [7:0]             kind_reg,         kind_next;
    logic [15:0]            remain_reg,       remain_next;
    logic [6:0]             entry_ofs_reg,    entry_ofs_next;
    logic [7:0]             held_keys_reg,    held_keys_next;
    logic [ENTRY_CNT_W-1:0] entries_reg,      entries_next;
    logic                   error_reg,        error_next;

    // result register
    logic        out_valid_reg;
    logic        accepted_reg,  accepted_next;
    logic [4:0]  count_reg,     count_next;
    logic [31:0] out_crc_reg,   out_crc_next;

    logic        advance;
    logic [31:0] crc_upd;

    // a byte without last never needs the result register
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    assign out_valid   = out_valid_reg;
    assign accepted    = accepted_reg;
    assign entry_count = count_reg;
    assign payload_crc = out_crc_reg;

    bdsv_crc8 u_crc (
        .crc_in  (crc_reg),
        .data    (in_byte_reg),
        .crc_out (crc_upd)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_type_max_reg   <= 8'd1;
            key_valid_mask_reg  <= 8'd15;
            ltk_key_bit_reg     <= 8'd2;
            flag_valid_mask_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ADDR_TYPE_MAX:   addr_type_max_reg   <= cfg_data;
                REG_KEY_VALID_MASK:  key_valid_mask_reg  <= cfg_data;
                REG_LTK_KEY_BIT:     ltk_key_bit_reg     <= cfg_data;
                REG_FLAG_VALID_MASK: flag_valid_mask_reg <= cfg_data;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
    end

    // per-byte walk, checks and verdict
    always_comb
    begin
        logic [7:0]  b;
        logic [4:0]  o;
        logic [1:0]  ro;
        logic [15:0] rem_dec;

        b = in_byte_reg;
        o = byte_offset_reg;
        ro = byte_offset_reg[1:0];
        rem_dec = remain_reg - 16'd1;

        phase_next       = phase_reg;
        byte_offset_next = byte_offset_reg;
        hdr_count_next   = hdr_count_reg;
        decl_len_next    = decl_len_reg;
        exp_crc_next     = exp_crc_reg;
        crc_next         = crc_reg;
        seen_next        = seen_reg;
        kind_next        = kind_reg;
        remain_next      = remain_reg;
        entry_ofs_next   = entry_ofs_reg;
        held_keys_next   = held_keys_reg;
        entries_next     = entries_reg;
        error_next       = error_reg;

        unique case (phase_reg)
            PH_RECHDR, PH_BODY:
            begin
                crc_next = crc_upd;
                // payload length accounting
                if (seen_reg < decl_len_reg)
                    seen_next = seen_reg + 32'd1;
                else
                    error_next = 1'b1;

                if (phase_reg == PH_RECHDR)
                begin
                    // record header: kind, reserved, le16 length
                    case (ro)
                        2'd0:
                        begin
                            kind_next   = b;
                            remain_next = 16'd0;
                        end
                        2'd1:
                        begin
                            if (b != 8'd0)
                                error_next = 1'b1;
                        end
                        2'd2:    remain_next = {8'd0, b};
                        default: remain_next = {b, remain_reg[7:0]};
                    endcase
                    if (ro != 2'd3)
                    begin
                        byte_offset_next = {3'd0, ro + 2'd1};
                    end
                    else
                    begin
                        byte_offset_next = 5'd0;
                        entry_ofs_next   = 7'd0;
                        held_keys_next   = 8'd0;
                        if (kind_reg == KIND_ENTRY && remain_next != ENTRY_BYTES)
                            error_next = 1'b1;
                        phase_next = (remain_next == 16'd0) ? PH_RECHDR : PH_BODY;
                    end
                end
                else
                begin
                    // entry field checks
                    if (kind_reg == KIND_ENTRY)
                    begin
                        if (entry_ofs_reg == OFS_ADAPTER_TYPE || entry_ofs_reg == OFS_PEER_TYPE)
                        begin
                            if (b > addr_type_max_reg)
                                error_next = 1'b1;
                        end
                        else if (entry_ofs_reg == OFS_KEYS)
                        begin
                            held_keys_next = b;
                            if ((b & ~key_valid_mask_reg) != 8'd0)
                                error_next = 1'b1;
                        end
                        else if (entry_ofs_reg == OFS_FLAGS)
                        begin
                            if ((b & ~flag_valid_mask_reg) != 8'd0)
                                error_next = 1'b1;
                        end
                        else if (entry_ofs_reg == OFS_LTK_SIZE)
                        begin
                            if ((held_keys_reg & ltk_key_bit_reg) != 8'd0
                                && (b < LTK_MIN || b > LTK_MAX))
                                error_next = 1'b1;
                        end
                        if (entry_ofs_reg != OFS_SAT)
                            entry_ofs_next = entry_ofs_reg + 7'd1;
                    end
                    remain_next = rem_dec;
                    // end of record body
                    if (rem_dec == 16'd0)
                    begin
                        if (kind_reg == KIND_ENTRY)
                        begin
                            if (32'(entries_reg) <= MAX_ENTRIES)
                                entries_next = entries_reg + 1'b1;
                            if (32'(entries_next) > MAX_ENTRIES)
                                error_next = 1'b1;
                        end
                        phase_next       = PH_RECHDR;
                        byte_offset_next = 5'd0;
                    end
                end
            end
            default:
            begin
                // fixed 20-byte header
                if (o < 5'd4)
                begin
                    if (b != MAGIC[o[1:0]])
                        error_next = 1'b1;
                end
                else if (o == 5'd4)
                begin
                    if (b != HDR_VERSION)
                        error_next = 1'b1;
                end
                else if (o == 5'd6)
                begin
                    if (b != HDR_LEN)
                        error_next = 1'b1;
                end
                else if (o == 5'd5 || o == 5'd7 || o == 5'd10 || o == 5'd11)
                begin
                    if (b != 8'd0)
                        error_next = 1'b1;
                end
                else if (o == 5'd8)
                begin
                    hdr_count_next[7:0] = hdr_count_reg[7:0] | b;
                end
                else if (o == 5'd9)
                begin
                    hdr_count_next[15:8] = hdr_count_reg[15:8] | b;
                    if (32'(hdr_count_next) > MAX_ENTRIES)
                        error_next = 1'b1;
                end
                else if (o >= 5'd12 && o < 5'd16)
                begin
                    decl_len_next = decl_len_reg | ({24'd0, b} << {o[1:0], 3'b000});
                end
                else if (o >= 5'd16 && o < 5'd20)
                begin
                    exp_crc_next = exp_crc_reg | ({24'd0, b} << {o[1:0], 3'b000});
                end
                if (o >= HDR_LAST)
                begin
                    phase_next       = PH_RECHDR;
                    byte_offset_next = 5'd0;
                end
                else
                begin
                    byte_offset_next = o + 5'd1;
                end
            end
        endcase

        // verdict from the updated state
        accepted_next = !error_next && phase_next == PH_RECHDR && byte_offset_next == 5'd0
                        && seen_next == decl_len_next && ~crc_next == exp_crc_next
                        && 16'(entries_next) == hdr_count_next;
        count_next   = sat_count(entries_next);
        out_crc_next = ~crc_next;
    end

    // walk state register, cleared after each image
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            byte_offset_reg <= 5'd0;
            hdr_count_reg   <= 16'd0;
            decl_len_reg    <= 32'd0;
            exp_crc_reg     <= 32'd0;
            crc_reg         <= CRC_INIT;
            seen_reg        <= 32'd0;
            kind_reg        <= 8'd0;
            remain_reg      <= 16'd0;
            entry_ofs_reg   <= 7'd0;
            held_keys_reg   <= 8'd0;
            entries_reg     <= '0;
            error_reg       <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg       <= PH_HEADER;
                byte_offset_reg <= 5'd0;
                hdr_count_reg   <= 16'd0;
                decl_len_reg    <= 32'd0;
                exp_crc_reg     <= 32'd0;
                crc_reg         <= CRC_INIT;
                seen_reg        <= 32'd0;
                kind_reg        <= 8'd0;
                remain_reg      <= 16'd0;
                entry_ofs_reg   <= 7'd0;
                held_keys_reg   <= 8'd0;
                entries_reg     <= '0;
                error_reg       <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                byte_offset_reg <= byte_offset_next;
                hdr_count_reg   <= hdr_count_next;
                decl_len_reg    <= decl_len_next;
                exp_crc_reg     <= exp_crc_next;
                crc_reg         <= crc_next;
                seen_reg        <= seen_next;
                kind_reg        <= kind_next;
                remain_reg      <= remain_next;
                entry_ofs_reg   <= entry_ofs_next;
                held_keys_reg   <= held_keys_next;
                entries_reg     <= entries_next;
                error_reg       <= error_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            accepted_reg <= accepted_next;
            count_reg    <= count_next;
            out_crc_reg  <= out_crc_next;
        end
    end

endmodule

`default_nettype wire
